// File: rtl/core/dnt_pkg.sv
// Shared types, codes and constants of the directory name table.
package dnt_pkg;

  // Table geometry
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BYTES       = 20;
  localparam int NAME_BYTES      = 20;
  localparam int QUEUE_DEPTH     = 2;

  // Channel widths
  localparam int IN_TDATA_W  = 160;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 168;
  localparam int OUT_TUSER_W = 3;
  localparam int POS_W       = 5;

  // Operation codes
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_EXISTS   = 3'd1;
  localparam logic [2:0] ST_DELETED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_ENTRY    = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  typedef logic [KEY_BYTES-1:0][7:0] key_t;

  typedef struct packed {
    logic [1:0] op;
    key_t       key;
  } cmd_t;

endpackage

// File: rtl/core/dnt_front.sv
// Front end: accepts command items, drops undefined operations, normalizes names.
module dnt_front import dnt_pkg::*; (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,  // name_low, name_mid, name_high
  input  logic [IN_TUSER_W-1:0] in_tuser,  // func
  output logic                  push,
  output cmd_t                  push_cmd,
  input  logic                  q_full
);

  // A name ends at its first zero byte; bytes past NAME_BYTES never count.
  function automatic key_t normalize(input key_t k);
    key_t r;
    logic live;
    live = 1'b1;
    for (int b = 0; b < KEY_BYTES; b++) begin
      live = live && (b < NAME_BYTES) && (k[b] != 8'h00);
      r[b] = live ? k[b] : 8'h00;
    end
    return r;
  endfunction

  logic op_ok;

  assign op_ok     = (in_tuser == OP_CREATE) || (in_tuser == OP_DELETE) ||
                     (in_tuser == OP_LIST);
  assign in_tready = !q_full;
  // Drop undefined operations at the door: they give no result.
  assign push      = in_tvalid && in_tready && op_ok;
  assign push_cmd.op  = in_tuser;
  assign push_cmd.key = normalize(key_t'(in_tdata));

endmodule

// File: rtl/core/dnt_queue.sv
// Short command queue between the front end and the table engine.
module dnt_queue import dnt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/dnt_engine.sv
// Table engine: name memory, scan/shift/list sequencer and result register.
module dnt_engine import dnt_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // position, entry_low, entry_mid, entry_high
  output logic [OUT_TUSER_W-1:0] out_tuser,  // status
  output logic                   out_tlast   // last
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_LIST  = 2'd3;

  key_t          mem [MAX_ENTRIES];
  key_t          rdata_r;
  logic [1:0]    state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  key_t          key_r, key_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          we;
  logic [IW-1:0] waddr;
  key_t          wdata;

  logic             ld_ok, tbl_empty, tbl_full, at_last, hit;
  logic             res_ld;
  logic [2:0]       res_status;
  logic [POS_W-1:0] res_pos;
  key_t             res_entry;
  logic             res_last;
  logic [IW:0]      pos_w;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [POS_W-1:0] out_pos_r;
  key_t             out_entry_r;
  logic             out_last_r;

  assign ld_ok     = !out_valid_r || out_tready;
  assign tbl_empty = (count_r == '0);
  assign tbl_full  = (count_r == CW'(MAX_ENTRIES));
  assign at_last   = ((CW'(idx_r) + CW'(1)) == count_r);
  assign hit       = !tbl_empty && (rdata_r == key_r);
  assign pos_w     = {1'b0, idx_r} + (IW + 1)'(1);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = idx_r;
    wdata      = rdata_r;
    res_ld     = 1'b0;
    res_status = ST_CREATED;
    res_pos    = '0;
    res_entry  = '0;
    res_last   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_cmd.op;
          key_nxt   = q_cmd.key;
          idx_nxt   = '0;
          state_nxt = (q_cmd.op == OP_LIST) ? S_LIST : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (op_r == OP_CREATE) begin
            if (ld_ok) begin
              res_ld     = 1'b1;
              res_status = ST_EXISTS;
              state_nxt  = S_IDLE;
            end
          end else if (at_last) begin
            if (ld_ok) begin
              res_ld     = 1'b1;
              res_status = ST_DELETED;
              count_nxt  = count_r - CW'(1);
              state_nxt  = S_IDLE;
            end
          end else begin
            // close the gap: move later entries down one place
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_SHIFT;
          end
        end else if (tbl_empty || at_last) begin
          if (ld_ok) begin
            res_ld    = 1'b1;
            state_nxt = S_IDLE;
            if (op_r == OP_CREATE) begin
              if (tbl_full) begin
                res_status = ST_FULL;
              end else begin
                res_status = ST_CREATED;
                we         = 1'b1;
                waddr      = count_r[IW-1:0];
                wdata      = key_r;
                count_nxt  = count_r + CW'(1);
              end
            end else begin
              res_status = ST_NOTFOUND;
            end
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = idx_r - IW'(1);
        wdata = rdata_r;
        if (at_last) begin
          if (ld_ok) begin
            res_ld     = 1'b1;
            res_status = ST_DELETED;
            count_nxt  = count_r - CW'(1);
            state_nxt  = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_LIST: begin
        if (ld_ok) begin
          res_ld = 1'b1;
          if (tbl_empty) begin
            res_status = ST_EMPTY;
            state_nxt  = S_IDLE;
          end else begin
            res_status = ST_ENTRY;
            res_pos    = POS_W'(pos_w);
            res_entry  = rdata_r;
            res_last   = at_last;
            if (at_last) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + IW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Read address follows the next index, so rdata_r always holds entry idx_r.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      if (res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    key_r <= key_nxt;
    if (res_ld) begin
      out_status_r <= res_status;
      out_pos_r    <= res_pos;
      out_entry_r  <= res_entry;
      out_last_r   <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - POS_W - KEY_BYTES * 8)'(0), out_entry_r, out_pos_r};

endmodule

// File: rtl/core/directory_name_table_top.sv
// Top level of the directory name table.
//
// Input channel in_*: one command item per handshake; in_tuser carries the
// operation (create, delete, list), in_tdata the 20-byte name. Names are cut
// at their first zero byte. Undefined operations are dropped without result.
// Output channel out_*: result items; out_tuser carries the status, out_tdata
// the position and the listed name, out_tlast marks the final result of an item.
// Create and delete give one result; list gives one per stored entry, or one
// "empty" result. Entries are held in a single-port-write, registered-read
// memory of MAX_ENTRIES names.
// Timing: a create or delete scans one entry per cycle, and a delete then
// shifts one later entry per cycle; a list emits one entry per cycle while
// the receiver is ready. The pace is set by the one memory read port. A
// two-deep command queue lets new items be accepted while the engine works.
// Reset empties the table at once. When the receiver stalls, the result
// register holds and the engine waits; the queue keeps taking items until
// it fills.
module directory_name_table_top import dnt_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // name_low, name_mid, name_high
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // position, entry_low, entry_mid, entry_high
  output logic [OUT_TUSER_W-1:0] out_tuser,  // status
  output logic                   out_tlast   // last
);

  logic push, q_full, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  dnt_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  dnt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  dnt_engine #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/directory_name_table_checker.sv
// Checker for the directory name table: predicts results from accepted commands and compares.
module directory_name_table_checker import dnt_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // name_low, name_mid, name_high
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // func
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // position, entry_low, entry_mid, entry_high
  input  logic [OUT_TUSER_W-1:0] out_tuser,  // status
  input  logic                   out_tlast,
  output int                     mismatch_count,
  output int                     results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]       status;
    logic [POS_W-1:0] position;
    key_t             name;
    logic             last;
  } table_result_t;

  key_t          table_names [MAX_ENTRIES];
  int            table_count = 0;
  table_result_t expected_results [$];
  int            mismatches = 0;
  int            queued = 0;

  assign mismatch_count  = mismatches;
  assign results_pending = queued;

  // Cut a name at its first zero byte and drop anything past NAME_BYTES.
  function automatic key_t trim_name(key_t raw);
    key_t name;
    logic ended;
    name  = raw;
    ended = 1'b0;
    for (int k = 0; k < KEY_BYTES; k++) begin
      if (k >= NAME_BYTES || raw[k] == 8'h00) ended = 1'b1;
      if (ended) name[k] = 8'h00;
    end
    return name;
  endfunction

  function automatic void predict_command(logic [1:0] op, key_t raw);
    key_t          name;
    int            hit;
    table_result_t res;
    name = trim_name(raw);
    hit  = -1;
    for (int i = 0; i < table_count; i++)
      if (hit < 0 && table_names[i] == name) hit = i;
    res      = '0;
    res.last = 1'b1;
    case (op)
      OP_CREATE: begin
        // a duplicate wins over a full table
        if (hit >= 0) begin
          res.status = ST_EXISTS;
        end else if (table_count >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          table_names[table_count] = name;
          table_count++;
          res.status = ST_CREATED;
        end
        expected_results.push_back(res);
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          for (int j = hit; j + 1 < table_count; j++) table_names[j] = table_names[j + 1];
          table_count--;
          res.status = ST_DELETED;
        end else begin
          res.status = ST_NOTFOUND;
        end
        expected_results.push_back(res);
      end
      OP_LIST: begin
        if (table_count == 0) begin
          res.status = ST_EMPTY;
          expected_results.push_back(res);
        end else begin
          for (int i = 0; i < table_count; i++) begin
            res.status   = ST_ENTRY;
            res.position = POS_W'(i + 1);
            res.name     = table_names[i];
            res.last     = (i + 1 == table_count);
            expected_results.push_back(res);
          end
        end
      end
      default: ;  // undefined operation: dropped without a result
    endcase
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  function automatic void check_result();
    table_result_t    want;
    logic [POS_W-1:0] got_pos;
    logic [63:0]      got_low;
    logic [63:0]      got_mid;
    logic [31:0]      got_high;
    got_pos  = out_tdata[4:0];
    got_low  = out_tdata[68:5];
    got_mid  = out_tdata[132:69];
    got_high = out_tdata[164:133];
    if (expected_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected item status=%0d pos=%0d last=%0b",
                              out_tuser, got_pos, out_tlast));
      return;
    end
    want = expected_results.pop_front();
    if (out_tuser !== want.status || got_pos !== want.position ||
        got_low !== 64'(want.name[7:0]) || got_mid !== 64'(want.name[15:8]) ||
        got_high !== 32'(want.name[19:16]) || out_tlast !== want.last)
      flag_mismatch($sformatf({"expected status=%0d pos=%0d name=%h_%h_%h last=%0b, ",
                               "got status=%0d pos=%0d name=%h_%h_%h last=%0b"},
                              want.status, want.position, want.name[19:16],
                              want.name[15:8], want.name[7:0], want.last,
                              out_tuser, got_pos, got_high, got_mid, got_low, out_tlast));
  endfunction

  // Compare before predicting: a result at this edge belongs to an older command.
  always @(posedge clk) begin
    if (!rst_n) begin
      table_count = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) predict_command(in_tuser, key_t'(in_tdata));
    end
    queued = expected_results.size();
  end

endmodule

// File: tb/directory_name_table_top_tb.sv
// Testbench top for the directory name table: clock, reset, commands, watchdog and verdict.
module directory_name_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dnt_pkg::*;

  localparam int         STALL_LIMIT  = 2000;
  localparam int         RANDOM_ITEMS = 270;
  localparam int         POOL_SIZE    = 24;
  localparam int         DRAIN_CYCLES = 40;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;
  int                     mismatch_count;
  int                     results_pending;

  key_t name_pool [POOL_SIZE];
  logic sender_quiet = 1'b0;

  always #2 clk = ~clk;

  directory_name_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  directory_name_table_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  function automatic int name_length(key_t name);
    int len;
    len = 0;
    while (len < KEY_BYTES && name[len] != 8'h00) len++;
    return len;
  endfunction

  function automatic key_t make_name(int len);
    key_t name;
    name = '0;
    for (int k = 0; k < len; k++) name[k] = 8'($urandom_range(1, 255));
    return name;
  endfunction

  // Fill the bytes past the terminator with noise; the block must ignore them.
  function automatic key_t add_tail_noise(key_t name, int noise_pct);
    key_t dressed;
    int   len;
    dressed = name;
    len     = name_length(name);
    if ($urandom_range(99) < noise_pct)
      for (int k = len + 1; k < KEY_BYTES; k++) dressed[k] = 8'($urandom);
    return dressed;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (sender_quiet || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Enter and leave at a falling edge.
  task automatic send_cmd(logic [1:0] op, key_t name);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= name;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Replace one pool name, sometimes by a near copy of another.
  task automatic refresh_pool();
    int   slot;
    int   len;
    int   k;
    key_t name;
    slot = $urandom_range(POOL_SIZE - 1);
    if ($urandom_range(3) == 0) begin
      name = name_pool[$urandom_range(POOL_SIZE - 1)];
      len  = name_length(name);
      if (len == 0) begin
        name = make_name(1);
      end else begin
        k = $urandom_range(len - 1);
        name[k] = name[k] ^ 8'($urandom_range(1, 255));
        if (name[k] == 8'h00) name[k] = 8'h5A;
      end
    end else begin
      name = make_name(($urandom_range(3) == 0) ? KEY_BYTES : $urandom_range(0, 19));
    end
    name_pool[slot] = name;
  endtask

  // Receiver: mostly short stalls, a few long ones, and always-ready stretches.
  initial begin : ready_gen
    int span;
    int roll;
    forever begin
      @(negedge clk);
      roll = $urandom_range(99);
      if (roll < 15) begin
        out_tready <= 1'b1;
        span = $urandom_range(20, 80);
      end else if (roll < 80) begin
        out_tready <= 1'b1;
        span = $urandom_range(1, 6);
      end else if (roll < 97) begin
        out_tready <= 1'b0;
        span = $urandom_range(1, 4);
      end else begin
        out_tready <= 1'b0;
        span = $urandom_range(15, 40);
      end
      repeat (span - 1) @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int         roll;
    int         create_pct;
    int         delete_pct;
    logic [1:0] op;
    key_t       name;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, empty key, widest key, short keys, delete with shift,
    // undefined operation, fill to full, duplicate on a full table.
    sender_quiet = 1'b1;
    name_pool[0] = '0;
    name_pool[1] = '1;
    name_pool[2] = make_name(1);
    name_pool[3] = make_name(19);
    send_cmd(OP_LIST, add_tail_noise(make_name(5), 100));
    send_cmd(OP_CREATE, add_tail_noise(name_pool[0], 100));
    send_cmd(OP_CREATE, add_tail_noise(name_pool[0], 100));
    send_cmd(OP_CREATE, name_pool[1]);
    send_cmd(OP_CREATE, add_tail_noise(name_pool[2], 100));
    send_cmd(OP_CREATE, name_pool[3]);
    send_cmd(OP_DELETE, add_tail_noise(make_name(2), 100));
    send_cmd(OP_DELETE, name_pool[1]);
    send_cmd(OP_UNDEFINED, '1);
    sender_quiet = 1'b0;
    for (int k = 4; k < 17; k++) begin
      name_pool[k] = make_name($urandom_range(1, KEY_BYTES));
      send_cmd(OP_CREATE, add_tail_noise(name_pool[k], 50));
    end
    send_cmd(OP_CREATE, make_name(KEY_BYTES));
    send_cmd(OP_CREATE, add_tail_noise(name_pool[2], 100));
    send_cmd(OP_LIST, '1);
    send_cmd(OP_DELETE, add_tail_noise(name_pool[0], 100));
    for (int k = 17; k < POOL_SIZE; k++) name_pool[k] = make_name($urandom_range(0, KEY_BYTES));
    wait_for_drain();

    // Random: phases lean toward filling, draining, or an even mix.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) sender_quiet = ($urandom_range(3) == 0);
      if (n % 30 == 29) refresh_pool();
      if (n == 120 || n == 220) wait_for_drain();
      case ((n / 40) % 3)
        0: begin
          create_pct = 55;
          delete_pct = 20;
        end
        1: begin
          create_pct = 20;
          delete_pct = 55;
        end
        default: begin
          create_pct = 38;
          delete_pct = 38;
        end
      endcase
      roll = $urandom_range(99);
      if (roll < create_pct) op = OP_CREATE;
      else if (roll < create_pct + delete_pct) op = OP_DELETE;
      else if (roll < 96) op = OP_LIST;
      else op = OP_UNDEFINED;
      if ($urandom_range(99) < 6) name = make_name($urandom_range(0, KEY_BYTES));
      else name = name_pool[$urandom_range(POOL_SIZE - 1)];
      send_cmd(op, add_tail_noise(name, 50));
    end
    in_tvalid <= 1'b0;

    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
